// File: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg - shared types and constants of the text console writer
//
// Opcodes, character codes, field widths and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Field widths of the request and response channels
   localparam int OPCODE_W    = 3;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int COL_FIELD_W = 7;
   localparam int ROW_FIELD_W = 5;
   localparam int LINEAR_W    = 11;
   localparam int CELL_W      = CHAR_W + ATTR_W;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;

   typedef logic [OPCODE_W-1:0] opcode_type;

   // Opcodes
   localparam opcode_type OP_PUT_CHAR   = 3'd0;
   localparam opcode_type OP_BACKSPACE  = 3'd1;
   localparam opcode_type OP_SET_CURSOR = 3'd2;
   localparam opcode_type OP_CLEAR      = 3'd3;
   localparam opcode_type OP_READ_CELL  = 3'd4;

   // Character codes with special meaning
   localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

   // Attribute after reset
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;

   typedef enum logic [2:0] {
      KIND_PRINT,
      KIND_NL,
      KIND_CR,
      KIND_BS,
      KIND_TAB
   } char_kind_type;

   // Commands from the controller
   typedef struct packed {
      logic load;             // latch the request
      logic put;              // write character at cursor and advance
      logic newline;          // cursor to start of next row
      logic back;             // step back and blank the cell
      logic set_pos;          // cursor to requested position
      logic home;             // cursor to origin
      logic sweep_rst;        // restart the sweep address
      logic copy;             // copy one cell up by one row
      logic fill;             // write one blank cell at the sweep address
      logic fill_reset_attr;  // blank with the reset attribute
      logic read_cell;        // read the requested cell
      logic respond;          // load the response register
   } tcw_cmd_type;

   // Status back to the controller
   typedef struct packed {
      opcode_type    op;
      char_kind_type kind;
      logic          wrap_bottom;  // put at the last cell of the screen
      logic          last_row;     // cursor on the bottom row
      logic          tab_last;     // next put is the last space of a tab
      logic          tab_more;     // tab still has spaces to write
      logic          copy_last;    // last cell of the scroll copy
      logic          sweep_last;   // sweep at the last cell
      logic          out_free;     // response register can take a result
   } tcw_status_type;

endpackage

// File: hw/rtl/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top - text console engine over a character cell screen
//
// Takes put-character, backspace, set-cursor, clear and read-cell requests
// and answers each with the cursor position and, for reads, the cell.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_* (opcode in tuser), one response per request
//   leaves on rsp_*. The color register is written on csr_* at any time and
//   is always ready; write it only while no request is in flight.
//   One request is worked at a time. A response is held in an output
//   register, so the next request is taken while it waits for rsp_tready.
//   Set cursor, backspace, read cell, newline, carriage return and the
//   unused opcodes go from dispatch straight to the response step; a
//   printable character adds a put step and a tab a put per space. A
//   request that scrolls copies each cell below the top row one row up,
//   then blanks the bottom row. Clear blanks the screen one cell per cycle.
//   After reset the screen store is swept to blanks with attribute 7, one
//   cell per cycle, with req_tready low.
//   A stalled response holds its payload and stalls the next request at its
//   response step only.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // char_code[7:0], col[14:8], row[19:15], zero[23:20]
   input  logic [tcw_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode[2:0]
   input  logic [tcw_pkg::OPCODE_W-1:0]      req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cursor_col[6:0], cursor_row[11:7], cursor_linear[22:12],
   // cell_char[30:23], cell_attr[38:31], zero[39]
   output logic [tcw_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]        csr_wdata
);
   import tcw_pkg::*;

   tcw_cmd_type    cmd;
   tcw_status_type status;

   logic [COL_FIELD_W-1:0] cursor_col;
   logic [ROW_FIELD_W-1:0] cursor_row;
   logic [LINEAR_W-1:0]    cursor_linear;
   logic [CHAR_W-1:0]      cell_char;
   logic [ATTR_W-1:0]      cell_attr;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcw_datapath #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_tuser),
      .req_char_code     (req_tdata[7:0]),
      .req_col           (req_tdata[14:8]),
      .req_row           (req_tdata[19:15]),
      .csr_valid         (csr_valid),
      .csr_wdata         (csr_wdata),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_cursor_col    (cursor_col),
      .rsp_cursor_row    (cursor_row),
      .rsp_cursor_linear (cursor_linear),
      .rsp_cell_char     (cell_char),
      .rsp_cell_attr     (cell_attr)
   );

   // The color register takes a write in any cycle
   assign csr_ready = 1'b1;

   // Pack the response fields
   assign rsp_tdata = {1'b0, cell_attr, cell_char, cursor_linear, cursor_row, cursor_col};

endmodule

// File: hw/rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl - sequencer of the text console writer
//
// Walks each request through dispatch, character writes, scroll copy,
// blank fill and response, issuing one command bundle per cycle.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  tcw_pkg::tcw_status_type status,
   output tcw_pkg::tcw_cmd_type    cmd
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT_FILL,
      ST_IDLE,
      ST_DISPATCH,
      ST_PUT,
      ST_SCROLL_COPY,
      ST_SCROLL_DRAIN,
      ST_FILL,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;

   // Decode state and status into commands and the next state
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT_FILL: begin
            cmd.fill            = 1'b1;
            cmd.fill_reset_attr = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_RESPOND;
            unique case (status.op)
               OP_PUT_CHAR: begin
                  unique case (status.kind)
                     KIND_NL: begin
                        cmd.newline = 1'b1;
                        if (status.last_row) begin
                           cmd.sweep_rst = 1'b1;
                           state_in      = ST_SCROLL_COPY;
                        end
                     end
                     KIND_CR: ;
                     KIND_BS: cmd.back = 1'b1;
                     KIND_TAB, KIND_PRINT: state_in = ST_PUT;
                     default: ;
                  endcase
               end
               OP_BACKSPACE:  cmd.back = 1'b1;
               OP_SET_CURSOR: cmd.set_pos = 1'b1;
               OP_CLEAR: begin
                  cmd.sweep_rst = 1'b1;
                  state_in      = ST_FILL;
               end
               OP_READ_CELL:  cmd.read_cell = 1'b1;
               default: ;
            endcase
         end
         ST_PUT: begin
            cmd.put = 1'b1;
            priority if (status.wrap_bottom) begin
               cmd.sweep_rst = 1'b1;
               state_in      = ST_SCROLL_COPY;
            end else if (status.kind == KIND_TAB && !status.tab_last) begin
               state_in = ST_PUT;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_SCROLL_COPY: begin
            cmd.copy = 1'b1;
            if (status.copy_last) begin
               state_in = ST_SCROLL_DRAIN;
            end
         end
         ST_SCROLL_DRAIN: begin
            // let the last copied cell land before the blank fill
            state_in = ST_FILL;
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (status.sweep_last) begin
               priority if (status.op == OP_CLEAR) begin
                  cmd.home = 1'b1;
                  state_in = ST_RESPOND;
               end else if (status.op == OP_PUT_CHAR && status.kind == KIND_TAB &&
                            status.tab_more) begin
                  state_in = ST_PUT;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_RESPOND: begin
            if (status.out_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath - screen store, cursor and response register
//
// Holds the cell memory, cursor, color register, sweep address and the
// response register, and carries out the controller's commands.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tcw_pkg::tcw_cmd_type                 cmd,
   output tcw_pkg::tcw_status_type              status,
   input  tcw_pkg::opcode_type                  req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]           req_char_code,
   input  logic [tcw_pkg::COL_FIELD_W-1:0]      req_col,
   input  logic [tcw_pkg::ROW_FIELD_W-1:0]      req_row,
   input  logic                                 csr_valid,
   input  logic [tcw_pkg::ATTR_W-1:0]           csr_wdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [tcw_pkg::COL_FIELD_W-1:0]      rsp_cursor_col,
   output logic [tcw_pkg::ROW_FIELD_W-1:0]      rsp_cursor_row,
   output logic [tcw_pkg::LINEAR_W-1:0]         rsp_cursor_linear,
   output logic [tcw_pkg::CHAR_W-1:0]           rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]           rsp_cell_attr
);
   import tcw_pkg::*;

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int TAB_CNT_W = $clog2(TAB_WIDTH + 1);

   localparam logic [COL_FIELD_W-1:0] COL_LIMIT = COL_FIELD_W'(COLUMNS - 1);
   localparam logic [ROW_FIELD_W:0]   ROW_LIMIT = (ROW_FIELD_W + 1)'(ROWS - 1);
   localparam logic [COL_W-1:0]       LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]       LAST_ROW  = ROW_W'(ROWS - 1);

   function automatic logic [ADDR_W-1:0] cell_lin(input logic [ROW_W-1:0] y,
                                                 input logic [COL_W-1:0] x);
      return ADDR_W'(ADDR_W'(y) * ADDR_W'(COLUMNS)) + ADDR_W'(x);
   endfunction

   // Screen store
   logic [CELL_W-1:0] cells_mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   // Latched request
   opcode_type         op_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ROW_W-1:0]   row_ff;

   // Control registers
   logic [COL_W-1:0]     cur_x_ff;
   logic [ROW_W-1:0]     cur_y_ff;
   logic [ATTR_W-1:0]    color_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [ADDR_W-1:0]    wr_addr_ff;
   logic                 pipe_valid_ff;
   logic [TAB_CNT_W-1:0] tab_cnt_ff;
   logic                 rsp_valid_ff;

   // Response payload
   logic [COL_FIELD_W-1:0] rsp_col_ff;
   logic [ROW_FIELD_W-1:0] rsp_row_ff;
   logic [LINEAR_W-1:0]    rsp_lin_ff;
   logic [CHAR_W-1:0]      rsp_char_ff;
   logic [ATTR_W-1:0]      rsp_attr_ff;

   char_kind_type          kind;
   logic                   at_origin;
   logic [COL_W-1:0]       back_x;
   logic [ROW_W-1:0]       back_y;
   logic [COL_FIELD_W-1:0] col_clamped;
   logic [ROW_FIELD_W:0]   row_clamped;
   logic [ATTR_W-1:0]      fill_attr;
   logic [CHAR_W-1:0]      put_char;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [CELL_W-1:0]      mem_wdata;
   logic                   mem_re;
   logic [ADDR_W-1:0]      mem_raddr;
   logic                   out_free;

   // Classify the latched character
   always_comb begin
      unique case (char_ff)
         CH_NL:   kind = KIND_NL;
         CH_CR:   kind = KIND_CR;
         CH_BS:   kind = KIND_BS;
         CH_TAB:  kind = KIND_TAB;
         default: kind = KIND_PRINT;
      endcase
   end

   // Clamp the requested position to the screen
   assign col_clamped = (req_col > COL_LIMIT) ? COL_LIMIT : req_col;
   assign row_clamped = ({1'b0, req_row} > ROW_LIMIT) ? ROW_LIMIT : {1'b0, req_row};

   // Backspace target
   assign at_origin = (cur_x_ff == '0) && (cur_y_ff == '0);
   assign back_x    = (cur_x_ff == '0) ? LAST_COL : cur_x_ff - COL_W'(1);
   assign back_y    = (cur_x_ff == '0) ? cur_y_ff - ROW_W'(1) : cur_y_ff;

   assign fill_attr = cmd.fill_reset_attr ? RESET_ATTR : color_ff;
   assign put_char  = (kind == KIND_TAB) ? CH_SPACE : char_ff;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Select the memory write: pending copy first, then fill, put, backspace
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = {fill_attr, CH_SPACE};
      priority if (pipe_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = wr_addr_ff;
         mem_wdata = rd_data_ff;
      end else if (cmd.fill) begin
         mem_we    = 1'b1;
      end else if (cmd.put) begin
         mem_we    = 1'b1;
         mem_waddr = cell_lin(cur_y_ff, cur_x_ff);
         mem_wdata = {color_ff, put_char};
      end else if (cmd.back && !at_origin) begin
         mem_we    = 1'b1;
         mem_waddr = cell_lin(back_y, back_x);
         mem_wdata = {color_ff, CH_SPACE};
      end
   end

   // Select the memory read: one row below for copy, else the requested cell
   assign mem_re    = cmd.copy || cmd.read_cell;
   assign mem_raddr = cmd.copy ? addr_ff + ADDR_W'(COLUMNS) : cell_lin(row_ff, col_ff);

   // Write the store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_mem[mem_waddr] <= mem_wdata;
      end
   end

   // Read the store
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= cells_mem[mem_raddr];
      end
   end

   // Latch the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         char_ff <= req_char_code;
         col_ff  <= COL_W'(col_clamped);
         row_ff  <= ROW_W'(row_clamped);
      end
   end

   // Cursor, color, sweep address and tab count
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         color_ff      <= RESET_ATTR;
         addr_ff       <= '0;
         wr_addr_ff    <= '0;
         pipe_valid_ff <= 1'b0;
         tab_cnt_ff    <= '0;
      end else begin
         if (csr_valid) begin
            color_ff <= csr_wdata;
         end

         // advance cursor
         priority if (cmd.put) begin
            if (cur_x_ff == LAST_COL) begin
               cur_x_ff <= '0;
               if (cur_y_ff != LAST_ROW) begin
                  cur_y_ff <= cur_y_ff + ROW_W'(1);
               end
            end else begin
               cur_x_ff <= cur_x_ff + COL_W'(1);
            end
         end else if (cmd.newline) begin
            cur_x_ff <= '0;
            if (cur_y_ff != LAST_ROW) begin
               cur_y_ff <= cur_y_ff + ROW_W'(1);
            end
         end else if (cmd.back) begin
            if (!at_origin) begin
               cur_x_ff <= back_x;
               cur_y_ff <= back_y;
            end
         end else if (cmd.set_pos) begin
            cur_x_ff <= col_ff;
            cur_y_ff <= row_ff;
         end else if (cmd.home) begin
            cur_x_ff <= '0;
            cur_y_ff <= '0;
         end

         // step the sweep
         priority if (cmd.sweep_rst) begin
            addr_ff <= '0;
         end else if (cmd.copy || cmd.fill) begin
            addr_ff <= addr_ff + ADDR_W'(1);
         end

         pipe_valid_ff <= cmd.copy;
         wr_addr_ff    <= addr_ff;

         // count tab spaces
         priority if (cmd.load) begin
            tab_cnt_ff <= '0;
         end else if (cmd.put) begin
            tab_cnt_ff <= tab_cnt_ff + TAB_CNT_W'(1);
         end
      end
   end

   // Response handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the response payload
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_col_ff <= COL_FIELD_W'(cur_x_ff);
         rsp_row_ff <= ROW_FIELD_W'(cur_y_ff);
         rsp_lin_ff <= LINEAR_W'(cell_lin(cur_y_ff, cur_x_ff));
         if (op_ff == OP_READ_CELL) begin
            rsp_char_ff <= rd_data_ff[CHAR_W-1:0];
            rsp_attr_ff <= rd_data_ff[CELL_W-1:CHAR_W];
         end else begin
            rsp_char_ff <= '0;
            rsp_attr_ff <= '0;
         end
      end
   end

   // Status to the controller
   always_comb begin
      status             = '0;
      status.op          = op_ff;
      status.kind        = kind;
      status.wrap_bottom = (cur_x_ff == LAST_COL) && (cur_y_ff == LAST_ROW);
      status.last_row    = (cur_y_ff == LAST_ROW);
      status.tab_last    = (tab_cnt_ff == TAB_CNT_W'(TAB_WIDTH - 1));
      status.tab_more    = (tab_cnt_ff != TAB_CNT_W'(TAB_WIDTH));
      status.copy_last   = (addr_ff == ADDR_W'(CELLS - COLUMNS - 1));
      status.sweep_last  = (addr_ff == ADDR_W'(CELLS - 1));
      status.out_free    = out_free;
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_linear = rsp_lin_ff;
   assign rsp_cell_char     = rsp_char_ff;
   assign rsp_cell_attr     = rsp_attr_ff;

endmodule
